// File: src/adts_stream_scanner_unit_macros.svh
// Assertion macros shared by the scanner checker.
`ifndef ADTS_STREAM_SCANNER_UNIT_MACROS_SVH
`define ADTS_STREAM_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ADTSS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adtss check failed");

// Next-cycle implication, idle during reset.
`define ADTSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adtss check failed");

`endif

// File: src/adtss_pkg.sv
// Types, constants and helper functions of the ADTS stream scanner.
`timescale 1ns / 1ps
package adtss_pkg;

  localparam int WinDepth   = 10;
  localparam int HdrBytes   = 6;
  localparam int SearchSpan = WinDepth - HdrBytes + 1;

  typedef logic [3:0]                 fill_t;
  typedef logic [WinDepth-1:0][7:0]   win_t;
  typedef logic [12:0]                flen_t;

  localparam fill_t FullFill = 4'd10;
  localparam fill_t HdrFill  = 4'd6;

  localparam logic [7:0] SyncByte   = 8'hFF;
  localparam logic [7:0] SyncMask   = 8'hF6;
  localparam logic [7:0] SyncMatch  = 8'hF0;
  localparam logic [7:0] FooterFlag = 8'h10;
  localparam logic [7:0] SafeBit    = 8'h80;
  localparam logic [7:0] NoVersion  = 8'hFF;
  localparam logic [7:0] Id3Char0   = 8'h49;
  localparam logic [7:0] Id3Char1   = 8'h44;
  localparam logic [7:0] Id3Char2   = 8'h33;

  localparam flen_t       MinFrameLen = 13'd7;
  localparam logic [31:0] TagHdrLen   = 32'd10;
  localparam logic [31:0] TagFootLen  = 32'd20;

  typedef enum logic [5:0] {
    PH_HEAD   = 6'b000001,
    PH_SKIP   = 6'b000010,
    PH_SEARCH = 6'b000100,
    PH_FHEAD  = 6'b001000,
    PH_BODY   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  typedef struct packed {
    logic        search;
    win_t        win;
    fill_t       fill;
    logic [31:0] spos;
    logic [31:0] frames;
    logic [39:0] acc;
  } scan_req_t;

  typedef struct packed {
    phase_t      phase;
    win_t        win;
    fill_t       fill;
    logic [31:0] spos;
    logic [31:0] frames;
    logic [39:0] acc;
    flen_t       left;
    logic        found;
    logic [1:0]  prof;
    logic [3:0]  ridx;
    logic [2:0]  chan;
    logic        cut;
  } scan_rsp_t;

  typedef struct packed {
    logic        id3_present;
    logic [7:0]  id3_major;
    logic [7:0]  id3_revision;
    logic [31:0] audio_start;
    logic        sync_seen;
    logic [31:0] frame_total;
    logic [39:0] length_sum;
    logic [1:0]  profile_code;
    logic [3:0]  rate_index;
    logic [16:0] rate_hz;
    logic [2:0]  channel_code;
    logic        cut_short;
  } res_t;

  function automatic logic is_sync(input logic [7:0] b0, input logic [7:0] b1);
    return (b0 == SyncByte) && ((b1 & SyncMask) == SyncMatch);
  endfunction

  // Drop n leading bytes of the window, zero fill at the back.
  function automatic win_t shift_win(input win_t w, input fill_t n);
    logic [4:0] k;
    win_t       r;
    for (int j = 0; j < WinDepth; j++) begin
      k = 5'(j) + {1'b0, n};
      r[j] = (k < 5'(WinDepth)) ? w[k[3:0]] : 8'h00;
    end
    return r;
  endfunction

  function automatic logic [16:0] rate_lookup(input logic [3:0] idx);
    logic [16:0] r;
    unique case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// File: src/adtss_frame_scan.sv
// Window scan: sync search over the byte window, then one frame header step.
`timescale 1ns / 1ps
module adtss_frame_scan (
  input  adtss_pkg::scan_req_t req,
  output adtss_pkg::scan_rsp_t rsp
);

  logic                 found;
  adtss_pkg::fill_t     off;
  adtss_pkg::fill_t     shift;
  adtss_pkg::win_t      w1;
  adtss_pkg::fill_t     f1;
  adtss_pkg::flen_t     flen;

  always_comb begin
    found = 1'b0;
    off   = '0;
    for (int i = 0; i < adtss_pkg::SearchSpan; i++) begin
      if (!found && req.search && (req.fill >= adtss_pkg::fill_t'(i + adtss_pkg::HdrBytes))
          && adtss_pkg::is_sync(req.win[i], req.win[i+1])) begin
        found = 1'b1;
        off   = adtss_pkg::fill_t'(i);
      end
    end

    // no sync: drop down to five bytes, the most that cannot hold a header
    if (found) begin
      shift = off;
    end else if (req.search && (req.fill >= adtss_pkg::HdrFill)) begin
      shift = req.fill - adtss_pkg::fill_t'(adtss_pkg::HdrBytes - 1);
    end else begin
      shift = '0;
    end

    w1   = adtss_pkg::shift_win(req.win, shift);
    f1   = req.fill - shift;
    flen = {w1[3][1:0], w1[4], w1[5][7:5]};

    rsp.phase  = (req.search && !found) ? adtss_pkg::PH_SEARCH : adtss_pkg::PH_FHEAD;
    rsp.win    = w1;
    rsp.fill   = f1;
    rsp.spos   = req.spos + {28'd0, shift};
    rsp.frames = req.frames;
    rsp.acc    = req.acc;
    rsp.left   = '0;
    rsp.found  = found;
    rsp.prof   = w1[2][7:6];
    rsp.ridx   = w1[2][5:2];
    rsp.chan   = {w1[2][0], w1[3][7:6]};
    rsp.cut    = 1'b0;

    if ((rsp.phase == adtss_pkg::PH_FHEAD) && (f1 >= adtss_pkg::HdrFill)) begin
      if (!adtss_pkg::is_sync(w1[0], w1[1])) begin
        rsp.phase = adtss_pkg::PH_DONE;
      end else begin
        rsp.acc = req.acc + {27'd0, flen};
        if (flen < adtss_pkg::MinFrameLen) begin
          rsp.cut   = 1'b1;
          rsp.phase = adtss_pkg::PH_DONE;
        end else if (flen <= {9'd0, f1}) begin
          // whole frame already in the window
          rsp.frames = req.frames + 32'd1;
          rsp.win    = adtss_pkg::shift_win(w1, flen[3:0]);
          rsp.fill   = f1 - flen[3:0];
        end else begin
          rsp.left  = flen - {9'd0, f1};
          rsp.fill  = '0;
          rsp.phase = adtss_pkg::PH_BODY;
        end
      end
    end
  end

endmodule

// File: src/adtss_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
`timescale 1ns / 1ps
module adtss_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  adtss_pkg::res_t res_in,
  input  logic            out_ready,
  output logic            out_valid,
  output adtss_pkg::res_t res_out,
  output logic            room
);

  logic            valid_r;
  logic            valid_nxt;
  adtss_pkg::res_t res_r;

  assign room      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

endmodule

// File: src/adts_stream_scanner_unit.sv
// The summary appears on out_valid in the cycle after the final byte is accepted.
// One byte per cycle while in_ready is high; bytes are scanned in head, search and fhead.
// Input stalls only while a summary waits in the result register and out_ready is low.
// Reset (rst_n low, synchronous) clears the scan state and the result valid; the scan
// state also returns to its reset values after each final byte.
`timescale 1ns / 1ps
module adts_stream_scanner_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_id3_present,
  output logic [7:0]  out_id3_major,
  output logic [7:0]  out_id3_revision,
  output logic [31:0] out_audio_start,
  output logic        out_sync_seen,
  output logic [31:0] out_frame_total,
  output logic [39:0] out_length_sum,
  output logic [1:0]  out_profile_code,
  output logic [3:0]  out_rate_index,
  output logic [16:0] out_rate_hz,
  output logic [2:0]  out_channel_code,
  output logic        out_cut_short
);

  adtss_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]       pos_r, pos_nxt;
  adtss_pkg::win_t   win_r, win_nxt;
  adtss_pkg::fill_t  fill_r, fill_nxt;
  logic [31:0]       tag_end_r, tag_end_nxt;
  adtss_pkg::flen_t  left_r, left_nxt;
  logic [31:0]       frames_r, frames_nxt;
  logic [39:0]       acc_r, acc_nxt;
  logic [1:0]        prof_r, prof_nxt;
  logic [3:0]        ridx_r, ridx_nxt;
  logic [2:0]        chan_r, chan_nxt;
  logic [31:0]       spos_r, spos_nxt;
  logic              id3_r, id3_nxt;
  logic [7:0]        major_r, major_nxt;
  logic [7:0]        rev_r, rev_nxt;
  logic              got_r, got_nxt;
  logic              cut_r, cut_nxt;

  logic                 fire;
  logic                 room;
  adtss_pkg::win_t      wp;
  adtss_pkg::fill_t     fp;
  logic                 id3_ok;
  logic [31:0]          tag_new;
  logic                 run_scan;
  adtss_pkg::scan_req_t req;
  adtss_pkg::scan_rsp_t rsp;
  adtss_pkg::res_t      res;
  adtss_pkg::res_t      res_q;

  assign in_ready = room;
  assign fire     = in_valid && room;

  // window with the new byte appended
  always_comb begin
    wp = win_r;
    fp = fill_r;
    if (fill_r < adtss_pkg::FullFill) begin
      wp[fill_r] = in_data_byte;
      fp         = fill_r + 4'd1;
    end
  end

  assign id3_ok = (wp[0] == adtss_pkg::Id3Char0) && (wp[1] == adtss_pkg::Id3Char1) &&
                  (wp[2] == adtss_pkg::Id3Char2) &&
                  (wp[3] != adtss_pkg::NoVersion) && (wp[4] != adtss_pkg::NoVersion) &&
                  ((wp[6] & adtss_pkg::SafeBit) == 8'h00) &&
                  ((wp[7] & adtss_pkg::SafeBit) == 8'h00) &&
                  ((wp[8] & adtss_pkg::SafeBit) == 8'h00) &&
                  ((wp[9] & adtss_pkg::SafeBit) == 8'h00);

  // synchsafe size plus header, plus footer when flagged
  assign tag_new = (((wp[5] & adtss_pkg::FooterFlag) != 8'h00) ?
                    adtss_pkg::TagFootLen : adtss_pkg::TagHdrLen) +
                   {4'd0, wp[6][6:0], wp[7][6:0], wp[8][6:0], wp[9][6:0]};

  assign req.search = (phase_r != adtss_pkg::PH_FHEAD);
  assign req.win    = wp;
  assign req.fill   = fp;
  assign req.spos   = (phase_r == adtss_pkg::PH_HEAD) ? 32'd0 : spos_r;
  assign req.frames = frames_r;
  assign req.acc    = acc_r;

  adtss_frame_scan u_scan (
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r + 32'd1;
    win_nxt     = win_r;
    fill_nxt    = fill_r;
    tag_end_nxt = tag_end_r;
    left_nxt    = left_r;
    frames_nxt  = frames_r;
    acc_nxt     = acc_r;
    prof_nxt    = prof_r;
    ridx_nxt    = ridx_r;
    chan_nxt    = chan_r;
    spos_nxt    = spos_r;
    id3_nxt     = id3_r;
    major_nxt   = major_r;
    rev_nxt     = rev_r;
    got_nxt     = got_r;
    cut_nxt     = cut_r;
    run_scan    = 1'b0;

    unique case (phase_r)
      adtss_pkg::PH_HEAD: begin
        win_nxt  = wp;
        fill_nxt = fp;
        if ((fp == adtss_pkg::FullFill) && id3_ok) begin
          id3_nxt     = 1'b1;
          major_nxt   = wp[3];
          rev_nxt     = wp[4];
          tag_end_nxt = tag_new;
          fill_nxt    = '0;
          spos_nxt    = tag_new;
          phase_nxt   = (tag_new == pos_nxt) ? adtss_pkg::PH_SEARCH : adtss_pkg::PH_SKIP;
        end else if ((fp == adtss_pkg::FullFill) || in_final_byte) begin
          run_scan = 1'b1;
        end
      end
      adtss_pkg::PH_SKIP: begin
        if (pos_nxt == tag_end_r) begin
          phase_nxt = adtss_pkg::PH_SEARCH;
          fill_nxt  = '0;
        end
      end
      adtss_pkg::PH_SEARCH, adtss_pkg::PH_FHEAD: begin
        run_scan = 1'b1;
      end
      adtss_pkg::PH_BODY: begin
        if (left_r > 13'd1) begin
          left_nxt = left_r - 13'd1;
        end else begin
          left_nxt   = '0;
          frames_nxt = frames_r + 32'd1;
          fill_nxt   = '0;
          phase_nxt  = adtss_pkg::PH_FHEAD;
        end
      end
      adtss_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (run_scan) begin
      phase_nxt  = rsp.phase;
      win_nxt    = rsp.win;
      fill_nxt   = rsp.fill;
      spos_nxt   = rsp.spos;
      frames_nxt = rsp.frames;
      acc_nxt    = rsp.acc;
      left_nxt   = rsp.left;
      cut_nxt    = cut_r || rsp.cut;
      if (rsp.found) begin
        got_nxt  = 1'b1;
        prof_nxt = rsp.prof;
        ridx_nxt = rsp.ridx;
        chan_nxt = rsp.chan;
      end
    end
  end

  always_comb begin
    res.id3_present  = id3_nxt;
    res.id3_major    = major_nxt;
    res.id3_revision = rev_nxt;
    res.audio_start  = spos_nxt;
    res.sync_seen    = got_nxt;
    res.frame_total  = frames_nxt;
    res.length_sum   = acc_nxt;
    res.profile_code = prof_nxt;
    res.rate_index   = ridx_nxt;
    res.rate_hz      = got_nxt ? adtss_pkg::rate_lookup(ridx_nxt) : 17'd0;
    res.channel_code = chan_nxt;
    // a frame still open at end of file is truncated
    res.cut_short    = cut_nxt || (phase_nxt == adtss_pkg::PH_BODY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && in_final_byte)) begin
      phase_r   <= adtss_pkg::PH_HEAD;
      pos_r     <= '0;
      win_r     <= '0;
      fill_r    <= '0;
      tag_end_r <= '0;
      left_r    <= '0;
      frames_r  <= '0;
      acc_r     <= '0;
      prof_r    <= '0;
      ridx_r    <= '0;
      chan_r    <= '0;
      spos_r    <= '0;
      id3_r     <= 1'b0;
      major_r   <= '0;
      rev_r     <= '0;
      got_r     <= 1'b0;
      cut_r     <= 1'b0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      win_r     <= win_nxt;
      fill_r    <= fill_nxt;
      tag_end_r <= tag_end_nxt;
      left_r    <= left_nxt;
      frames_r  <= frames_nxt;
      acc_r     <= acc_nxt;
      prof_r    <= prof_nxt;
      ridx_r    <= ridx_nxt;
      chan_r    <= chan_nxt;
      spos_r    <= spos_nxt;
      id3_r     <= id3_nxt;
      major_r   <= major_nxt;
      rev_r     <= rev_nxt;
      got_r     <= got_nxt;
      cut_r     <= cut_nxt;
    end
  end

  adtss_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && in_final_byte),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_q),
    .room      (room)
  );

  assign out_id3_present  = res_q.id3_present;
  assign out_id3_major    = res_q.id3_major;
  assign out_id3_revision = res_q.id3_revision;
  assign out_audio_start  = res_q.audio_start;
  assign out_sync_seen    = res_q.sync_seen;
  assign out_frame_total  = res_q.frame_total;
  assign out_length_sum   = res_q.length_sum;
  assign out_profile_code = res_q.profile_code;
  assign out_rate_index   = res_q.rate_index;
  assign out_rate_hz      = res_q.rate_hz;
  assign out_channel_code = res_q.channel_code;
  assign out_cut_short    = res_q.cut_short;

endmodule

// File: src/adtss_checker.sv
// Port-level checks of the scanner, attached to the top level by bind.
`timescale 1ns / 1ps
`include "adts_stream_scanner_unit_macros.svh"
module adtss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_final_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_id3_present,
  input logic [7:0]  out_id3_major,
  input logic [7:0]  out_id3_revision,
  input logic [31:0] out_audio_start,
  input logic        out_sync_seen,
  input logic [31:0] out_frame_total,
  input logic [39:0] out_length_sum,
  input logic [16:0] out_rate_hz
);

  `ADTSS_ASSERT_NEXT(a_final_gives_result, in_valid && in_ready && in_final_byte, out_valid)
  `ADTSS_ASSERT_IMPLY(a_full_blocks_input, out_valid && !out_ready, !in_ready)
  `ADTSS_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
    out_valid && $stable(out_audio_start) && $stable(out_frame_total) &&
    $stable(out_length_sum))
  `ADTSS_ASSERT_IMPLY(a_no_sync_no_frames, out_valid && !out_sync_seen,
    out_frame_total == 32'd0 && out_length_sum == 40'd0 && out_rate_hz == 17'd0)
  `ADTSS_ASSERT_IMPLY(a_no_tag_no_version, out_valid && !out_id3_present,
    out_id3_major == 8'd0 && out_id3_revision == 8'd0)

endmodule

bind adts_stream_scanner_unit adtss_checker u_adtss_checker (.*);
